### hw/rtl/mbdf_pkg.sv
// Shared constants, types and helpers for the 2x2 mipmap downsampler with fade.
// Used by mip_box_downsample_fade, mbdf_blend, mbdf_checker; no dependencies.
`default_nettype none

package mbdf_pkg;

	localparam int DEFAULT_MAX_WIDTH = 4096;
	localparam int HEIGHT_CAP        = 4096;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_COLOR    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_TO_COLOR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_TO_ALPHA = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = 3'd5;

	localparam int DIM_W    = 13;
	localparam int WEIGHT_W = 9;
	localparam int CH       = 4;
	localparam int PAIR_W   = 9;
	localparam int SUM_W    = 10;
	localparam int BLEND_W  = 18;
	localparam int BOOST_W  = 22;

	localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 9'd256;

	typedef logic [CH-1:0][SUM_W-1:0] sum4_t;

	typedef struct packed {
		sum4_t sum;
		logic  last;
	} sum_item_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] w_color;
		logic [WEIGHT_W-1:0] w_alpha;
		logic [31:0]         fade;
	} blend_cfg_t;

	// channel order: 0 red, 1 green, 2 blue, 3 alpha
	function automatic logic [7:0] fade_byte(input logic [31:0] fade, input int k);
		logic [7:0] b;
		case (k)
			0:       b = fade[23:16];
			1:       b = fade[15:8];
			2:       b = fade[7:0];
			default: b = fade[31:24];
		endcase
		return b;
	endfunction

	function automatic logic [7:0] clamp8(input logic [BOOST_W-1:0] v);
		return (v > BOOST_W'(255)) ? 8'hFF : v[7:0];
	endfunction

endpackage

`default_nettype wire

### hw/rtl/mip_box_downsample_fade.sv
// Top level of the 2x2 box-filter mipmap downsampler with color/alpha fade.
// Depends on mbdf_pkg and mbdf_blend.
//
// channel | dir | handshake               | payload
// s_axis  | in  | s_axis_tvalid/tready    | tdata: red, green, blue, alpha; tuser: frame_start
// m_axis  | out | m_axis_tvalid/tready    | tdata: red, green, blue, alpha; tlast: frame_end
// wr      | in  | wr_en (no wait)         | wr_index, wr_data
//
// One source pixel is taken per clock while s_axis_tready is high. Pair sums of even rows
// live in a line memory of MAX_WIDTH/2 entries; the stored sum is fetched on the even pixel
// of an odd row and used on the following odd pixel through a registered read. A result
// passes the sum, blend and clamp registers after its odd-row, odd-column pixel is taken.
// Reset sets counters, valid bits and configuration; the line memory needs no clearing pass.
// A stall on m_axis backs up through the stages; input is refused only when all are full.
`default_nettype none

module mip_box_downsample_fade
	import mbdf_pkg::*;
#(
	parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [31:0]           s_axis_tdata,  // red, green, blue, alpha
	input  wire logic                  s_axis_tuser,  // frame_start
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [31:0]                m_axis_tdata,  // red, green, blue, alpha
	output logic                       m_axis_tlast,  // frame_end
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data
);

	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int AW  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WLW = $clog2(MAX_WIDTH + 1);
	localparam int RW  = $clog2(HEIGHT_CAP);
	localparam int LW  = CH * PAIR_W;

	// configuration
	logic [DIM_W-1:0]    image_width_q;
	logic [DIM_W-1:0]    image_height_q;
	logic [31:0]         fade_color_q;
	logic                fade_to_color_q;
	logic                fade_to_alpha_q;
	logic [WEIGHT_W-1:0] blend_weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= DIM_W'(4096);
			image_height_q  <= DIM_W'(4096);
			fade_color_q    <= '0;
			fade_to_color_q <= 1'b0;
			fade_to_alpha_q <= 1'b0;
			blend_weight_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_IMAGE_WIDTH:   image_width_q   <= wr_data[DIM_W-1:0];
				REG_IMAGE_HEIGHT:  image_height_q  <= wr_data[DIM_W-1:0];
				REG_FADE_COLOR:    fade_color_q    <= wr_data[31:0];
				REG_FADE_TO_COLOR: fade_to_color_q <= wr_data[0];
				REG_FADE_TO_ALPHA: fade_to_alpha_q <= wr_data[0];
				REG_BLEND_WEIGHT:  blend_weight_q  <= wr_data[WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	logic [WLW-1:0]      w_lim;
	logic [DIM_W-1:0]    h_lim;
	logic [WEIGHT_W-1:0] wt;
	blend_cfg_t          bcfg;

	always_comb begin
		if (image_width_q < DIM_W'(2)) begin
			w_lim = WLW'(2);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_lim = WLW'(MAX_WIDTH);
		end else begin
			w_lim = WLW'(image_width_q);
		end
		if (image_height_q < DIM_W'(2)) begin
			h_lim = DIM_W'(2);
		end else if (32'(image_height_q) > 32'(HEIGHT_CAP)) begin
			h_lim = DIM_W'(HEIGHT_CAP);
		end else begin
			h_lim = image_height_q;
		end
		wt           = (blend_weight_q > WEIGHT_FULL) ? WEIGHT_FULL : blend_weight_q;
		bcfg.w_color = fade_to_color_q ? wt : '0;
		bcfg.w_alpha = fade_to_alpha_q ? wt : '0;
		bcfg.fade    = fade_color_q;
	end

	// position tracking
	logic [CW-1:0]  col_q;
	logic [RW-1:0]  row_q;
	logic [CW-1:0]  col_base, col_eff, col_d;
	logic [RW-1:0]  row_base, row_eff, row_d;
	logic [WLW-1:0] col_inc;
	logic [DIM_W-1:0] row_inc;
	logic           accept;
	logic           odd_col, odd_row, is_last;
	logic [AW-1:0]  idx;

	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		col_base = s_axis_tuser ? '0 : col_q;
		row_base = s_axis_tuser ? '0 : row_q;
		col_eff  = (WLW'(col_base) >= w_lim) ? '0 : col_base;
		row_eff  = (DIM_W'(row_base) >= h_lim) ? '0 : row_base;
		col_inc  = WLW'(col_eff) + WLW'(1);
		row_inc  = DIM_W'(row_eff) + DIM_W'(1);
		if (col_inc >= w_lim) begin
			col_d = '0;
			row_d = (row_inc >= h_lim) ? '0 : RW'(row_inc);
		end else begin
			col_d = CW'(col_inc);
			row_d = row_eff;
		end
		odd_col = col_eff[0];
		odd_row = row_eff[0];
		idx     = AW'(col_eff >> 1);
		is_last = (WLW'(col_eff >> 1) == (w_lim >> 1) - WLW'(1)) &&
		          (DIM_W'(row_eff >> 1) == (h_lim >> 1) - DIM_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	// left pixel and pair sums
	logic [31:0]               hold_q;
	logic [CH-1:0][PAIR_W-1:0] pair;
	logic [LW-1:0]             pair_packed;

	always_comb begin
		for (int k = 0; k < CH; k++) begin
			pair[k] = {1'b0, hold_q[8*k +: 8]} + {1'b0, s_axis_tdata[8*k +: 8]};
			pair_packed[PAIR_W*k +: PAIR_W] = pair[k];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !odd_col) begin
			hold_q <= s_axis_tdata;
		end
	end

	// line memory: write on even rows, fetch ahead on the even pixel
	logic [LW-1:0] line_mem [LINE_DEPTH];
	logic [LW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (accept && odd_col && !odd_row) begin
			line_mem[idx] <= pair_packed;
		end
		if (accept && !odd_col) begin
			rd_q <= line_mem[idx];
		end
	end

	// stage 1: 2x2 sums
	logic      v_s1;
	sum_item_t item_s1;
	sum_item_t item_d;
	logic      blend_ready;
	logic      adv1;

	assign adv1          = !v_s1 || blend_ready;
	assign s_axis_tready = adv1;

	always_comb begin
		for (int k = 0; k < CH; k++) begin
			item_d.sum[k] = SUM_W'(rd_q[PAIR_W*k +: PAIR_W]) + SUM_W'(pair[k]);
		end
		item_d.last = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= accept && odd_col && odd_row;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && odd_col && odd_row) begin
			item_s1 <= item_d;
		end
	end

	mbdf_blend u_blend (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (v_s1),
		.in_ready      (blend_ready),
		.in_item       (item_s1),
		.cfg           (bcfg),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

### hw/rtl/mbdf_blend.sv
// Fade blend, alpha boost and clamp: two pipeline stages with output register.
// Depends on mbdf_pkg.
`default_nettype none

module mbdf_blend
	import mbdf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire sum_item_t  in_item,
	input  wire blend_cfg_t cfg,
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [31:0]     m_axis_tdata,  // red, green, blue, alpha
	output logic            m_axis_tlast   // frame_end
);

	logic                          v_s2;
	logic [CH-1:0][BLEND_W-1:0]    prod_s2;
	logic                          last_s2;
	logic [CH-1:0][BLEND_W-1:0]    prod_d;
	logic [31:0]                   data_d;
	logic                          out_adv;
	logic                          adv2;

	assign out_adv  = !m_axis_tvalid || m_axis_tready;
	assign adv2     = !v_s2 || out_adv;
	assign in_ready = adv2;

	// c*1024 = sum*(256-w) + 4*fade*w
	always_comb begin
		logic [BLEND_W-1:0] s_ext;
		logic [BLEND_W-1:0] inv;
		logic [BLEND_W-1:0] w_ext;
		logic [BLEND_W-1:0] f_ext;
		for (int k = 0; k < CH; k++) begin
			w_ext = (k < CH - 1) ? BLEND_W'(cfg.w_color) : BLEND_W'(cfg.w_alpha);
			s_ext = BLEND_W'(in_item.sum[k]);
			inv   = BLEND_W'(WEIGHT_FULL) - w_ext;
			f_ext = BLEND_W'({fade_byte(cfg.fade, k), 2'b00});
			prod_d[k] = s_ext * inv + f_ext * w_ext;
		end
	end

	always_comb begin
		logic [BOOST_W-1:0] a_ext;
		logic [BOOST_W-1:0] a_boost;
		for (int k = 0; k < CH - 1; k++) begin
			data_d[8*k +: 8] = clamp8(BOOST_W'(prod_s2[k] >> 10));
		end
		// alpha gains one eighth: 9*c >> 13
		a_ext   = BOOST_W'(prod_s2[CH-1]);
		a_boost = a_ext + (a_ext << 3);
		data_d[31:24] = clamp8(a_boost >> 13);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2          <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (adv2) begin
				v_s2 <= in_valid;
			end
			if (out_adv) begin
				m_axis_tvalid <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2 && in_valid) begin
			prod_s2 <= prod_d;
			last_s2 <= in_item.last;
		end
		if (out_adv && v_s2) begin
			m_axis_tdata <= data_d;
			m_axis_tlast <= last_s2;
		end
	end

endmodule

`default_nettype wire

### hw/rtl/mbdf_checker.sv
// Port-level checks for mip_box_downsample_fade, attached by bind.
// Depends on mbdf_pkg and the top level's port list.
`default_nettype none

module mbdf_checker
	import mbdf_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [31:0] s_axis_tdata,
	input wire logic        s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// hold a stalled source item
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
		s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
		else $error("stalled source item changed");

	// an empty output register means the pipeline has room
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input refused while output is empty");

	// the pipeline is empty after reset, so nothing leaves before input fills it
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_axis_tvalid [*3])
		else $error("result appeared too soon after reset");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("result valid during reset");

endmodule

bind mip_box_downsample_fade mbdf_checker u_mbdf_checker (.*);

`default_nettype wire
